### design/box_blur_3x3_rgb_top_macros.svh
// ---------------------------------------------------------------------------
// box blur assertion macros
// shared property forms for the checker of the box blur block
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_TOP_MACROS_SVH
`define BOX_BLUR_3X3_RGB_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define BB3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bb3_pkg.sv
// ---------------------------------------------------------------------------
// bb3_pkg
// types, register codes and the three-tap mean for the box blur block
// ---------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

    // frame height limit of the row counter
    localparam int unsigned MaxRows = 4096;

    // register reset values
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    // register index codes (byte address bit 2)
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // one incoming pixel
    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } pix_t;

    // one blurred result item
    typedef struct packed {
        logic [10:0] out_col;
        logic [11:0] out_row;
        logic [7:0]  blue_out;
        logic [7:0]  green_out;
        logic [7:0]  red_out;
        logic        run_last;
        logic        frame_done;
    } res_t;

    // internal pixel word, blue in the low byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // floor(s/3) for s up to 765 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] p;
        begin
            p = 21'(s) * 21'd683;
            return p[18:11];
        end
    endfunction

    // per-channel floor mean of three pixels
    function automatic rgb_t mean3(input rgb_t a, input rgb_t b, input rgb_t c);
        rgb_t res;
        begin
            res.red   = div3(10'(a.red)   + 10'(b.red)   + 10'(c.red));
            res.green = div3(10'(a.green) + 10'(b.green) + 10'(c.green));
            res.blue  = div3(10'(a.blue)  + 10'(b.blue)  + 10'(c.blue));
            return res;
        end
    endfunction

endpackage

`default_nettype wire

### design/box_blur_3x3_rgb_top.sv
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// separable 3x3 box blur over a raster stream of BGR pixels
// ---------------------------------------------------------------------------
// Usage:
//   pix channel takes one pixel per item in raster order; res channel gives
//   blurred pixels with their column and row, one row behind the input.
//   Both channels move an item when valid is high and stall is low.
//   Frame size comes from the image_width / image_height registers on the
//   APB port (byte addresses 0 and 4); write them only while idle.
//   A result passes stage a, stage b and the result register in turn.
//   Throughput: one pixel per cycle inside a row while res_stall is low; the
//   last column holds pix back as it forms two horizontal means, each needing a
//   read and a write of both line memories. In the last row, if not the first,
//   each mean yields two results, so the result port sets the rate there.
//   Reset clears the counters, pipeline valids and registers to 640x480;
//   the line memories are not cleared and need no clearing pass.
//   A stalled receiver holds the result register; the pipeline backs up and
//   pix_stall rises within the same cycle once the stages are full.
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb_top #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // pixel input channel
    input  wire logic          pix_valid,
    output logic               pix_stall,
    input  wire bb3_pkg::pix_t pix,
    // result output channel
    output logic               res_valid,
    input  wire logic          res_stall,
    output bb3_pkg::res_t      res,
    // configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bb3_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);

    // horizontal mean on its way through the vertical pass
    typedef struct packed {
        logic [CW-1:0] k;
        logic [11:0]   row;
        rgb_t          h;
        logic          has_prev;
        logic          last_row;
        logic          final_item;
        logic          frame_end;
    } hitem_t;

    logic [11:0]   image_width_reg;
    logic [12:0]   image_height_reg;
    logic [CW-1:0] col_count_reg;
    logic [11:0]   row_count_reg;
    rgb_t          prev_one_reg;
    rgb_t          prev_two_reg;

    logic          pend_valid_reg;
    hitem_t        pend_item_reg;
    logic          a_valid_reg;
    hitem_t        a_item_reg;
    logic          b_valid_reg;
    hitem_t        b_item_reg;
    logic          b_need_prev_reg;
    logic          b_need_cur_reg;
    rgb_t          older_rd_reg;
    rgb_t          newer_rd_reg;
    logic          fwd_reg;
    rgb_t          fwd_older_reg;
    rgb_t          fwd_newer_reg;
    logic          out_valid_reg;
    res_t          out_data_reg;

    rgb_t          mem_older [MAX_WIDTH];
    rgb_t          mem_newer [MAX_WIDTH];

    logic          cfg_wr;
    logic [CW-1:0] wm1;
    logic [11:0]   hm1;
    logic          last_col;
    logic          last_row;
    logic          accept;
    logic          a_load;
    logic          a_to_b;
    logic          out_load;
    logic          b_emit;
    logic          b_fin;
    logic          has0;
    rgb_t          pix_rgb;
    hitem_t        item0;
    hitem_t        item1;
    rgb_t          b_older_eff;
    rgb_t          b_newer_eff;
    rgb_t          prev_val;
    rgb_t          res_val;
    res_t          res_next;
    logic          last_of_item;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2:2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[11:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2:2])
            REG_IMAGE_WIDTH:  prdata = {20'd0, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {19'd0, image_height_reg};
            default:          prdata = '0;
        endcase
    end

    // saturated last column and last row
    always_comb
    begin
        if (image_width_reg == 12'd0)
            wm1 = '0;
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            wm1 = CW'(MAX_WIDTH - 1);
        else
            wm1 = CW'(image_width_reg - 12'd1);

        if (image_height_reg == 13'd0)
            hm1 = '0;
        else if (32'(image_height_reg) > 32'(MaxRows))
            hm1 = 12'(MaxRows - 1);
        else
            hm1 = 12'(image_height_reg - 13'd1);
    end

    assign last_col = col_count_reg >= wm1;
    assign last_row = row_count_reg >= hm1;

    // handshake and stage movement
    assign out_load = !out_valid_reg || !res_stall;
    assign b_emit   = b_valid_reg && (b_need_prev_reg || b_need_cur_reg) && out_load;
    assign b_fin    = b_valid_reg && (!(b_need_prev_reg || b_need_cur_reg) ||
                      (out_load && !(b_need_prev_reg && b_need_cur_reg)));
    assign a_to_b   = a_valid_reg && (!b_valid_reg || b_fin);
    assign a_load   = !a_valid_reg || a_to_b;
    assign pix_stall = pend_valid_reg || !a_load;
    assign accept   = pix_valid && !pix_stall;

    // horizontal means formed by the incoming pixel
    always_comb
    begin
        pix_rgb.red   = pix.red_in;
        pix_rgb.green = pix.green_in;
        pix_rgb.blue  = pix.blue_in;
        has0 = col_count_reg != '0;

        item0.k          = col_count_reg - CW'(1);
        item0.row        = row_count_reg;
        item0.h          = (col_count_reg >= CW'(2)) ?
                           mean3(prev_two_reg, prev_one_reg, pix_rgb) : prev_one_reg;
        item0.has_prev   = row_count_reg != 12'd0;
        item0.last_row   = last_row;
        item0.final_item = !last_col;
        item0.frame_end  = 1'b0;

        item1.k          = col_count_reg;
        item1.row        = row_count_reg;
        item1.h          = pix_rgb;
        item1.has_prev   = row_count_reg != 12'd0;
        item1.last_row   = last_row;
        item1.final_item = 1'b1;
        item1.frame_end  = last_row;
    end

    // position counters and pixel history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            prev_one_reg  <= '0;
            prev_two_reg  <= '0;
        end
        else if (accept)
        begin
            prev_two_reg <= prev_one_reg;
            prev_one_reg <= pix_rgb;
            if (last_col)
            begin
                col_count_reg <= '0;
                row_count_reg <= last_row ? 12'd0 : row_count_reg + 12'd1;
            end
            else
            begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
    end

    // stage a with a spare slot for the second mean of the last column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            if (pend_valid_reg)
            begin
                a_valid_reg    <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (accept && (has0 || last_col))
            begin
                a_valid_reg    <= 1'b1;
                pend_valid_reg <= has0 && last_col;
            end
            else
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            if (pend_valid_reg)
                a_item_reg <= pend_item_reg;
            else if (accept)
                a_item_reg <= has0 ? item0 : item1;
        end
        if (a_load && !pend_valid_reg && accept)
            pend_item_reg <= item1;
    end

    // stage b control: which of the two rows are still to be given
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg     <= 1'b0;
            b_need_prev_reg <= 1'b0;
            b_need_cur_reg  <= 1'b0;
            fwd_reg         <= 1'b0;
        end
        else if (a_to_b)
        begin
            b_valid_reg     <= 1'b1;
            b_need_prev_reg <= a_item_reg.has_prev;
            b_need_cur_reg  <= a_item_reg.last_row;
            fwd_reg         <= b_fin && (b_item_reg.k == a_item_reg.k);
        end
        else if (b_fin)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_emit)
        begin
            b_need_prev_reg <= 1'b0;
        end
    end

    // stage b payload with bypass of a write to the same column
    always_ff @(posedge clk)
    begin
        if (a_to_b)
        begin
            b_item_reg    <= a_item_reg;
            fwd_older_reg <= b_newer_eff;
            fwd_newer_reg <= b_item_reg.h;
        end
    end

    // line memories: read on entry to stage b, write when stage b retires
    always_ff @(posedge clk)
    begin
        if (a_to_b)
            older_rd_reg <= mem_older[a_item_reg.k];
        if (b_fin)
            mem_older[b_item_reg.k] <= b_newer_eff;
    end

    always_ff @(posedge clk)
    begin
        if (a_to_b)
            newer_rd_reg <= mem_newer[a_item_reg.k];
        if (b_fin)
            mem_newer[b_item_reg.k] <= b_item_reg.h;
    end

    // vertical mean and result assembly
    always_comb
    begin
        b_older_eff  = fwd_reg ? fwd_older_reg : older_rd_reg;
        b_newer_eff  = fwd_reg ? fwd_newer_reg : newer_rd_reg;
        prev_val     = (b_item_reg.row == 12'd1) ? b_newer_eff :
                       mean3(b_older_eff, b_newer_eff, b_item_reg.h);
        res_val      = b_need_prev_reg ? prev_val : b_item_reg.h;
        last_of_item = !(b_need_prev_reg && b_need_cur_reg);

        res_next.out_col    = 11'(b_item_reg.k);
        res_next.out_row    = b_need_prev_reg ? b_item_reg.row - 12'd1 : b_item_reg.row;
        res_next.blue_out   = res_val.blue;
        res_next.green_out  = res_val.green;
        res_next.red_out    = res_val.red;
        res_next.run_last   = b_item_reg.final_item && last_of_item;
        res_next.frame_done = b_item_reg.frame_end && last_of_item;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= b_emit;
    end

    always_ff @(posedge clk)
    begin
        if (b_emit)
            out_data_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

endmodule

`default_nettype wire

### design/bb3_checker.sv
// ---------------------------------------------------------------------------
// bb3_checker
// port-level checks of the box blur result stream
// ---------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_rgb_top_macros.svh"

module bb3_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          res_valid,
    input wire logic          res_stall,
    input wire bb3_pkg::res_t res
);
    import bb3_pkg::*;

    // a stalled result item holds
    `BB3_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

    // end of frame is always the last item of its pixel
    `BB3_ASSERT_NOW(a_done_last, clk, rst_n, res_valid && res.frame_done, res.run_last, "frame_done without run_last")

    // the results of one pixel leave without gaps
    `BB3_ASSERT_NEXT(a_run_gapless, clk, rst_n, res_valid && !res.run_last, res_valid, "gap inside a pixel's results")

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

### test/box_blur_3x3_rgb_checker.sv
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_checker
// watches the pixel, result and register channels of the box blur block,
// works out the blurred pixels each accepted item causes and compares every
// accepted result, field by field, with the oldest one still owed
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb_checker
    import bb3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    input  wire logic        pix_stall,
    input  wire pix_t        pix,
    input  wire logic        res_valid,
    input  wire logic        res_stall,
    input  wire res_t        res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               mismatches,
    output int               pending
);

    // horizontal means of the two rows above the current one
    rgb_t hline_older [MAX_WIDTH];
    rgb_t hline_newer [MAX_WIDTH];

    // pixels at columns c-1 and c-2
    rgb_t left_one;
    rgb_t left_two;

    // position of the next pixel and the frame size registers
    int unsigned col_pos;
    int unsigned row_pos;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    // blurred pixels still owed by the block
    res_t blur_owed [$];
    res_t step_out [4];
    int   step_n;
    int   errors = 0;

    // per-channel floor of the three-tap mean
    function automatic rgb_t floor_mean(input rgb_t a, input rgb_t b, input rgb_t c);
        rgb_t m;
        m.red   = 8'((int'(a.red) + int'(b.red) + int'(c.red)) / 3);
        m.green = 8'((int'(a.green) + int'(b.green) + int'(c.green)) / 3);
        m.blue  = 8'((int'(a.blue) + int'(b.blue) + int'(c.blue)) / 3);
        return m;
    endfunction

    task automatic add_blurred(input int unsigned k, input int unsigned row, input rgb_t v);
        res_t r;
        r.out_col    = 11'(k);
        r.out_row    = 12'(row);
        r.blue_out   = v.blue;
        r.green_out  = v.green;
        r.red_out    = v.red;
        r.run_last   = 1'b0;
        r.frame_done = 1'b0;
        step_out[step_n] = r;
        step_n++;
    endtask

    // vertical pass for one horizontal mean at (row, k)
    task automatic feed_column(input int unsigned row, input int unsigned k, input rgb_t hm,
                               input bit last_row);
        int unsigned i;
        i = (k < MAX_WIDTH) ? k : MAX_WIDTH - 1;
        if (row >= 1)
        begin
            if (row == 1)
                add_blurred(k, row - 1, hline_newer[i]);
            else
                add_blurred(k, row - 1, floor_mean(hline_older[i], hline_newer[i], hm));
        end
        // last row also gives its own row, border copy
        if (last_row)
            add_blurred(k, row, hm);
        hline_older[i] = hline_newer[i];
        hline_newer[i] = hm;
    endtask

    // work out the blurred pixels that one input pixel causes
    task automatic predict_blur(input pix_t p);
        int unsigned w;
        int unsigned h;
        rgb_t        cur;
        bit          last_col;
        bit          last_row;
        int          j;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MaxRows) ? MaxRows : height_reg);
        last_col  = col_pos >= w - 1;
        last_row  = row_pos >= h - 1;
        cur.red   = p.red_in;
        cur.green = p.green_in;
        cur.blue  = p.blue_in;
        step_n    = 0;
        // horizontal mean of the previous column, border copy at column 0
        if (col_pos >= 1)
        begin
            if (col_pos >= 2)
                feed_column(row_pos, col_pos - 1, floor_mean(left_two, left_one, cur), last_row);
            else
                feed_column(row_pos, col_pos - 1, left_one, last_row);
        end
        // last column passes through and is given at once
        if (last_col)
            feed_column(row_pos, col_pos, cur, last_row);
        if (step_n > 0)
        begin
            step_out[step_n - 1].run_last   = 1'b1;
            step_out[step_n - 1].frame_done = last_col && last_row;
        end
        for (j = 0; j < step_n; j++)
            blur_owed.push_back(step_out[j]);
        left_two = left_one;
        left_one = cur;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    function automatic int field_bad(input string name, input int unsigned want,
                                     input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // compare one accepted result with the oldest owed one
    task automatic check_blur(input res_t got);
        res_t want;
        if (blur_owed.size() == 0)
        begin
            $display("%0t: result col %0d row %0d expected none actual one", $time,
                     got.out_col, got.out_row);
            errors++;
        end
        else
        begin
            want = blur_owed.pop_front();
            errors += field_bad("out_col", want.out_col, got.out_col);
            errors += field_bad("out_row", want.out_row, got.out_row);
            errors += field_bad("blue_out", want.blue_out, got.blue_out);
            errors += field_bad("green_out", want.green_out, got.green_out);
            errors += field_bad("red_out", want.red_out, got.red_out);
            errors += field_bad("run_last", want.run_last, got.run_last);
            errors += field_bad("frame_done", want.frame_done, got.frame_done);
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            left_one   = '0;
            left_two   = '0;
            blur_owed.delete();
            mismatches <= errors;
            pending    <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_blur(res);
            if (pix_valid && !pix_stall)
                predict_blur(pix);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_IMAGE_WIDTH)
                    width_reg = pwdata[11:0];
                else if (paddr[2] == REG_IMAGE_HEIGHT)
                    height_reg = pwdata[12:0];
            end
            mismatches <= errors;
            pending    <= blur_owed.size();
        end
    end

endmodule

`default_nettype wire

### test/tb_box_blur_3x3_rgb_top.sv
// ---------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_top
// streams whole frames of pixels through the box blur block under random
// idling on both channels, reprograms the frame size between frames and
// at times in mid-frame, and gives the verdict from the checker's count
// ---------------------------------------------------------------------------
`default_nettype none

module tb_box_blur_3x3_rgb_top;

    import bb3_pkg::*;

    localparam int unsigned MAX_WIDTH     = 2048;
    localparam int unsigned PIXEL_ITEMS   = 220;
    localparam int unsigned CALM_ITEMS    = 60;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int          QUIET_LIMIT   = 2000;

    typedef enum {FILL_RANDOM, FILL_BLACK, FILL_WHITE, FILL_CHECKER} fill_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        pix_valid = 1'b0;
    pix_t        pix       = '0;
    logic        res_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    wire logic   pix_stall;
    wire logic   res_valid;
    res_t        res;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    bit          idling       = 1'b1;
    int unsigned sent_items   = 0;
    int unsigned frame_w      = 1;
    int unsigned frame_h      = 1;
    int          stall_left   = 0;
    int          quiet_cycles = 0;

    box_blur_3x3_rgb_top #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix      (pix),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    box_blur_3x3_rgb_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) blur_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // random receiver stall bursts, started only while idling is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (idling && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        res_stall <= (stall_left > 0);
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
            (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // channel value with the extremes made common
    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pix_t make_pixel(input fill_e fill, input int unsigned idx);
        pix_t p;
        case (fill)
            FILL_BLACK:   p = '0;
            FILL_WHITE:   p = '1;
            FILL_CHECKER: p = idx[0] ? '1 : '0;
            default:
            begin
                p.blue_in  = random_level();
                p.green_in = random_level();
                p.red_in   = random_level();
            end
        endcase
        return p;
    endfunction

    function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned top);
        return (raw == 0) ? 1 : ((raw > top) ? top : raw);
    endfunction

    // one pixel item, with an optional gap before it
    task automatic send_pixel(input pix_t p);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        pix       <= p;
        pix_valid <= 1'b1;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_run(input fill_e fill, input int unsigned count);
        int unsigned j;
        for (j = 0; j < count; j++)
            send_pixel(make_pixel(fill, j));
    endtask

    // wait until every owed result is out and the pipeline has settled
    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup and access cycle of one register write
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // new frame size, unused upper bits of the data filled at random
    task automatic set_frame(input int unsigned raw_w, input int unsigned raw_h);
        drain();
        write_reg(REG_IMAGE_WIDTH, ($urandom() & 32'hFFFF_F000) | raw_w[11:0]);
        write_reg(REG_IMAGE_HEIGHT, ($urandom() & 32'hFFFF_E000) | raw_h[12:0]);
        frame_w = clamp_size(raw_w[11:0], MAX_WIDTH);
        frame_h = clamp_size(raw_h[12:0], MaxRows);
    endtask

    initial
    begin
        int unsigned start_count;
        int unsigned raw_w;
        int unsigned raw_h;
        int unsigned cut_row;
        int unsigned cut_col;
        fill_e       fill;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame, flat white then a checkerboard
        set_frame(3, 3);
        send_run(FILL_WHITE, 9);
        send_run(FILL_CHECKER, 9);
        // tiny frames with border copies only, zero sizes saturate up
        set_frame(1, 1);
        send_run(FILL_RANDOM, 1);
        set_frame(2, 2);
        send_run(FILL_RANDOM, 4);
        set_frame(0, 0);
        send_run(FILL_CHECKER, 1);

        // oversized registers saturate to the widest row and the tallest frame
        set_frame(12'hFFF, 1);
        send_run(FILL_RANDOM, frame_w * frame_h);
        set_frame(1, 13'h1FFF);
        send_run(FILL_RANDOM, frame_w * frame_h);

        // random small frames, some cut short by a size change in mid-frame
        start_count = sent_items;
        while (sent_items < start_count + PIXEL_ITEMS)
        begin
            if (sent_items + CALM_ITEMS >= start_count + PIXEL_ITEMS)
                idling <= 1'b0;
            else
                idling <= ($urandom_range(0, 3) != 0);
            raw_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
            raw_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            set_frame(raw_w, raw_h);
            fill = ($urandom_range(0, 7) == 0) ? FILL_CHECKER : FILL_RANDOM;
            if (frame_h >= 2 && $urandom_range(0, 4) == 0)
            begin
                // shrink so the next pixel lands at or past the new last column and row
                cut_row = $urandom_range(1, frame_h - 1);
                cut_col = $urandom_range(0, frame_w - 1);
                send_run(fill, cut_row * frame_w + cut_col);
                set_frame($urandom_range(0, cut_col + 1), $urandom_range(0, cut_row + 1));
                send_run(FILL_RANDOM, 1);
            end
            else
            begin
                send_run(fill, frame_w * frame_h);
            end
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

### box_blur_3x3_rgb_top.f
+incdir+design
design/bb3_pkg.sv
design/box_blur_3x3_rgb_top.sv
design/bb3_checker.sv
test/box_blur_3x3_rgb_checker.sv
test/tb_box_blur_3x3_rgb_top.sv
